// File: rtl/tog_pkg.sv
package tog_pkg;

  // Fixed-point format of every word (signed, FRAC_W fraction bits)
  localparam int WORD_W = 32;
  localparam int FRAC_W = 27;

  // Orbit length limit and counter widths
  localparam int ITER_CAP = 64;
  localparam int ITER_W   = 7;
  localparam int CNT_W    = $clog2(ITER_CAP);

  // Escape compare: wide enough for the word and for 4.0
  localparam int CMP_W = (WORD_W > FRAC_W + 3) ? WORD_W : FRAC_W + 3;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [CMP_W-1:0] ESC_LIMIT = CMP_W'(64'd4 << FRAC_W);

  typedef struct packed {
    word_t c_real;
    word_t c_imag;
  } in_req_t;

  typedef struct packed {
    word_t z_real;
    word_t z_imag;
    logic  is_last;
    logic  escaped;
  } out_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL_XX,
    S_MUL_YY,
    S_MUL_XY,
    S_DRAIN,
    S_EVAL
  } state_t;

  typedef enum logic [1:0] {
    PROD_XX,
    PROD_YY,
    PROD_XY
  } prod_sel_t;

  typedef struct packed {
    logic      load_in;   // take a new start point
    logic      prep;      // latch operand magnitudes
    logic      issue;     // start one product
    prod_sel_t sel;       // which product
    logic      emit;      // load output register, step z
    logic      cnt_last;  // this point is the last by count
  } dp_cmd_t;

  typedef struct packed {
    logic esc;            // |z|^2 > 4 for the current point
  } dp_sts_t;

endpackage

// File: rtl/tog_dpath.sv
module tog_dpath
  import tog_pkg::*;
(
  input  logic     clk,
  input  in_req_t  in_data,
  input  dp_cmd_t  cmd,
  output dp_sts_t  sts,
  output out_req_t out_data
);

  localparam int W = WORD_W;
  localparam int F = FRAC_W;

  function automatic word_t sat_add(word_t a, word_t b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      return s[W] ? WORD_MIN : WORD_MAX;
    end
    return s[W-1:0];
  endfunction

  function automatic word_t sat_neg(word_t a);
    return (a == WORD_MIN) ? WORD_MAX : -a;
  endfunction

  word_t x_r, y_r, cr_r, ci_r;
  word_t xx_r, yy_r, xy_r;
  logic [W-1:0] xm_r, ym_r;
  logic [2*W-1:0] prod_r;
  prod_sel_t psel_r;
  logic pvld_r;
  out_req_t out_r;

  logic [W-1:0] op_a, op_b;
  logic over;
  logic [W-2:0] mag_val;
  logic prod_neg;
  word_t fx_res;
  word_t mag, nx, ny;
  logic esc;

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.sel)
      PROD_XX: begin
        op_a = xm_r;
        op_b = xm_r;
      end
      PROD_YY: begin
        op_a = ym_r;
        op_b = ym_r;
      end
      PROD_XY: begin
        op_a = xm_r;
        op_b = ym_r;
      end
      default: begin
        op_a = xm_r;
        op_b = ym_r;
      end
    endcase
  end

  // truncate magnitude toward zero, saturate to word
  always_comb begin
    over     = |prod_r[2*W-1:F+W-1];
    mag_val  = prod_r[F+W-2:F];
    prod_neg = (psel_r == PROD_XY) && (x_r[W-1] ^ y_r[W-1]);
    if (prod_neg) begin
      fx_res = over ? WORD_MIN : -$signed({1'b0, mag_val});
    end else begin
      fx_res = over ? WORD_MAX : $signed({1'b0, mag_val});
    end
  end

  always_comb begin
    mag = sat_add(xx_r, yy_r);
    esc = CMP_W'($unsigned(mag)) > ESC_LIMIT;
    nx  = sat_add(sat_add(xx_r, -yy_r), cr_r);
    ny  = sat_add(sat_neg(sat_add(xy_r, xy_r)), ci_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r  <= in_data.c_real;
      y_r  <= in_data.c_imag;
      cr_r <= in_data.c_real;
      ci_r <= in_data.c_imag;
    end else if (cmd.emit && !(esc || cmd.cnt_last)) begin
      x_r <= nx;
      y_r <= ny;
    end
    if (cmd.prep) begin
      xm_r <= x_r[W-1] ? W'(-x_r) : W'(x_r);
      ym_r <= y_r[W-1] ? W'(-y_r) : W'(y_r);
    end
    pvld_r <= cmd.issue;
    if (cmd.issue) begin
      prod_r <= op_a * op_b;
      psel_r <= cmd.sel;
    end
    if (pvld_r) begin
      case (psel_r)
        PROD_XX: xx_r <= fx_res;
        PROD_YY: yy_r <= fx_res;
        PROD_XY: xy_r <= fx_res;
        default: xy_r <= fx_res;
      endcase
    end
    if (cmd.emit) begin
      out_r.z_real  <= x_r;
      out_r.z_imag  <= y_r;
      out_r.is_last <= esc || cmd.cnt_last;
      out_r.escaped <= esc;
    end
  end

  assign sts.esc  = esc;
  assign out_data = out_r;

endmodule

// File: rtl/tog_ctrl.sv
module tog_ctrl
  import tog_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              cfg_we,
  input  logic [ITER_W-1:0] cfg_wdata,
  input  dp_sts_t           sts,
  output dp_cmd_t           cmd
);

  state_t state_r, state_nxt;
  logic [ITER_W-1:0] max_iter_r, max_iter_nxt;
  logic [ITER_W-1:0] limit_r, limit_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic out_valid_r, out_valid_nxt;
  logic in_fire, out_fire, can_emit, pt_last, cnt_last;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;
  assign can_emit = !out_valid_r || out_ready;
  assign cnt_last = ({1'b0, n_r} + ITER_W'(1)) == limit_r;
  assign pt_last  = sts.esc || cnt_last;

  always_comb begin
    state_nxt     = state_r;
    max_iter_nxt  = cfg_we ? cfg_wdata : max_iter_r;
    limit_nxt     = limit_r;
    n_nxt         = n_r;
    out_valid_nxt = out_fire ? 1'b0 : out_valid_r;
    cmd           = '0;
    cmd.sel       = PROD_XX;
    cmd.cnt_last  = cnt_last;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_in = 1'b1;
          n_nxt       = '0;
          if (max_iter_r == '0) begin
            limit_nxt = ITER_W'(1);
          end else if (max_iter_r > ITER_W'(ITER_CAP)) begin
            limit_nxt = ITER_W'(ITER_CAP);
          end else begin
            limit_nxt = max_iter_r;
          end
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_MUL_XX;
      end
      S_MUL_XX: begin
        cmd.issue = 1'b1;
        cmd.sel   = PROD_XX;
        state_nxt = S_MUL_YY;
      end
      S_MUL_YY: begin
        cmd.issue = 1'b1;
        cmd.sel   = PROD_YY;
        state_nxt = S_MUL_XY;
      end
      S_MUL_XY: begin
        cmd.issue = 1'b1;
        cmd.sel   = PROD_XY;
        state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (can_emit) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          if (pt_last) begin
            state_nxt = S_IDLE;
          end else begin
            n_nxt     = n_r + CNT_W'(1);
            state_nxt = S_PREP;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_iter_r  <= ITER_W'(ITER_CAP);
      limit_r     <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      max_iter_r  <= max_iter_nxt;
      limit_r     <= limit_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("point emitted over an untaken one");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> ({1'b0, n_r} < limit_r))
    else $error("point count beyond limit");

  a_limit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (limit_r >= ITER_W'(1) && limit_r <= ITER_W'(ITER_CAP)))
    else $error("limit out of range");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && pt_last) |=> (state_r == S_IDLE && out_valid_r))
    else $error("no return to idle after last point");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_PREP))
    else $error("accepted start point not processed");
`endif

endmodule

// File: rtl/tricorn_orbit_generator_top.sv
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     in_data  (c_real, c_imag)
// out_      output     out_valid / out_ready   out_data (z_real, z_imag, is_last, escaped)
// cfg_      input      cfg_we, no wait         cfg_wdata (max_iter)
//
// Each point steps through prep, three products on the one shared multiplier, drain
// and evaluate, in that order.
// A start point gives up to max_iter points, clamped to 1..64; max_iter 0 gives one.
// rst_n is synchronous, active low; it idles the controller and sets max_iter to 64.
// A stalled result holds in the output register and the orbit waits at evaluate;
// a new request is taken once the last point is loaded, even while it waits on out_ready.
module tricorn_orbit_generator_top
  import tog_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_req_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_req_t          out_data,
  input  logic              cfg_we,
  input  logic [ITER_W-1:0] cfg_wdata
);

  // controller to datapath commands and status
  dp_cmd_t cmd;
  dp_sts_t sts;

  tog_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .cmd       (cmd)
  );

  // z registers, magnitudes, product registers, saturation and escape test
  tog_dpath u_dpath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
